// ----- sv/bdpc_pkg.sv -----
// Shared types, codes and reset constants for the button debounce press classifier.
package bdpc_pkg;

    // Field and port widths
    localparam int unsigned CFG_DATA_WIDTH  = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 4;
    localparam int unsigned S_TDATA_WIDTH   = 8;
    localparam int unsigned M_TDATA_WIDTH   = 8;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS   = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS_TICKS = 4'd1;

    // Reset values: 20 ms debounce, 1 s long press at a 1 ms tick
    localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_TICKS_RESET   = 16'd20;
    localparam logic [CFG_DATA_WIDTH-1:0] LONG_PRESS_TICKS_RESET = 16'd1000;

    // Press event codes
    localparam logic [1:0] EVENT_NONE  = 2'd0;
    localparam logic [1:0] EVENT_SHORT = 2'd1;
    localparam logic [1:0] EVENT_LONG  = 2'd2;

    // Mode codes as reported on the result
    localparam logic [1:0] MODE_CODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_CODE_DEBOUNCE = 2'd1;
    localparam logic [1:0] MODE_CODE_HELD     = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_DEBOUNCE = 3'b010,
        MODE_HELD     = 3'b100
    } mode_t;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] debounce_ticks;
        logic [CFG_DATA_WIDTH-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] press_event;
        logic [1:0] machine_mode;
    } result_t;

endpackage

// ----- sv/bdpc_cfg_regs.sv -----
// Configuration register file: decodes write beats into the two settings.
module bdpc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output bdpc_pkg::cfg_t                       cfg
);
    import bdpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            // indexes past the list fall through untouched
            if (cfg_index == REG_DEBOUNCE_TICKS) begin
                cfg_next.debounce_ticks = cfg_data;
            end else if (cfg_index == REG_LONG_PRESS_TICKS) begin
                cfg_next.long_press_ticks = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_TICKS_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/bdpc_fsm.sv -----
// Debounce and hold state machine: edge detect, counters and press classification.
module bdpc_fsm #(
    parameter int unsigned COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              pin_level,
    input  bdpc_pkg::cfg_t    cfg,
    output bdpc_pkg::result_t result
);
    import bdpc_pkg::*;

    localparam int unsigned CMP_WIDTH =
        (COUNT_WIDTH > CFG_DATA_WIDTH) ? COUNT_WIDTH : CFG_DATA_WIDTH;

    logic                   prev_level_reg;
    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [COUNT_WIDTH-1:0] debounce_count_reg;
    logic [COUNT_WIDTH-1:0] debounce_count_next;
    logic [COUNT_WIDTH-1:0] hold_count_reg;
    logic [COUNT_WIDTH-1:0] hold_count_next;
    logic                   fall;
    logic                   rise;
    logic                   is_long;
    logic [1:0]             press_event;

    assign fall    = prev_level_reg & ~pin_level;
    assign rise    = ~prev_level_reg & pin_level;
    assign is_long = CMP_WIDTH'(hold_count_reg) >= CMP_WIDTH'(cfg.long_press_ticks);

    always_comb begin
        mode_next           = mode_reg;
        debounce_count_next = debounce_count_reg;
        hold_count_next     = hold_count_reg;
        press_event         = EVENT_NONE;
        unique case (mode_reg)
            MODE_DEBOUNCE: begin
                if (debounce_count_reg <= COUNT_WIDTH'(1)) begin
                    debounce_count_next = '0;
                    if (!pin_level) begin
                        hold_count_next = '0;
                        mode_next       = MODE_HELD;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end else begin
                    debounce_count_next = debounce_count_reg - COUNT_WIDTH'(1);
                end
            end
            MODE_HELD: begin
                if (rise) begin
                    press_event = is_long ? EVENT_LONG : EVENT_SHORT;
                    mode_next   = MODE_IDLE;
                end else if (hold_count_reg != '1) begin
                    hold_count_next = hold_count_reg + COUNT_WIDTH'(1);
                end
            end
            MODE_IDLE: begin
                if (fall) begin
                    debounce_count_next = COUNT_WIDTH'(cfg.debounce_ticks);
                    mode_next           = MODE_DEBOUNCE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                if (fall) begin
                    debounce_count_next = COUNT_WIDTH'(cfg.debounce_ticks);
                    mode_next           = MODE_DEBOUNCE;
                end
            end
        endcase
    end

    always_comb begin
        result.press_event = press_event;
        unique case (mode_next)
            MODE_DEBOUNCE: result.machine_mode = MODE_CODE_DEBOUNCE;
            MODE_HELD:     result.machine_mode = MODE_CODE_HELD;
            default:       result.machine_mode = MODE_CODE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg     <= 1'b1;
            mode_reg           <= MODE_IDLE;
            debounce_count_reg <= '0;
            hold_count_reg     <= '0;
        end else if (advance) begin
            prev_level_reg     <= pin_level;
            mode_reg           <= mode_next;
            debounce_count_reg <= debounce_count_next;
            hold_count_reg     <= hold_count_next;
        end
    end

endmodule

// ----- sv/bdpc_out_stage.sv -----
// Result register between the state machine and the master-side stream.
module bdpc_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  bdpc_pkg::result_t                  result,
    output logic                               space,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bdpc_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import bdpc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // room when empty or when the held beat leaves this cycle
    assign space      = ~valid_reg | m_tready;
    assign valid_next = load | (valid_reg & ~m_tready);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {{(M_TDATA_WIDTH - 4){1'b0}},
                         result_reg.machine_mode, result_reg.press_event};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ----- sv/button_debounce_press_classifier.sv -----
// Top level of the button debounce press classifier.
//
// One pin sample enters per beat on the slave side and exactly one result beat
// leaves per sample on the master side, in order. A sample is taken every
// cycle as long as the result register is empty or its beat is being taken in
// the same cycle, so the sustained rate is one sample per clock; the result is
// registered and appears in the cycle after the sample is accepted. The state
// machine, its edge detector and both counters update in the accepting cycle;
// the only storage on the data path is the one-beat result register, which
// sets the throughput under back-pressure. Counters are COUNT_WIDTH bits wide;
// the hold counter saturates at all ones. Configuration writes are always
// ready and should be issued only while no sample is in flight.
module button_debounce_press_classifier #(
    parameter int unsigned COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bdpc_pkg::S_TDATA_WIDTH-1:0]   s_tdata,  // [0] pin_level, rest zero
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bdpc_pkg::M_TDATA_WIDTH-1:0]   m_tdata   // [1:0] press_event,
                                                           // [3:2] machine_mode
);
    import bdpc_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    space;
    logic    accept;

    // a sample beat moves when the result register can take its result
    assign s_tready = space;
    assign accept   = s_tvalid & space;

    bdpc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdpc_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .pin_level (s_tdata[0]),
        .cfg       (cfg),
        .result    (result)
    );

    bdpc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/bdpc_checker.sv -----
// Port-level checker for the classifier, bound to the top level.
module bdpc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [bdpc_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);
    import bdpc_pkg::*;

    // a stalled result beat keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no sample stall when the result side has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("sample side stalled with result room");

    // a press is only reported on the release that ends the hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != EVENT_NONE |-> m_tdata[3:2] == MODE_CODE_IDLE)
        else $error("press event outside idle");

    // an event leaves held mode, and only held mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[3:2] == MODE_CODE_IDLE
        ##1 m_tvalid && (m_tdata[1:0] == EVENT_SHORT || m_tdata[1:0] == EVENT_LONG)
        |-> 1'b0)
        else $error("press event without a preceding hold");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
